// ----- rtl/esm_pkg.sv -----
// Package for the ELLPACK sparse matrix-vector block: widths, codes and the queue entry.
`default_nettype none
package esm_pkg;

    localparam int VEC_DEPTH  = 4096;
    localparam int MAX_SLOTS  = 64;
    localparam int MAX_ROWS   = 65536;

    localparam int IDX_W      = 12;
    localparam int VAL_W      = 32;
    localparam int ACC_W      = 64;
    localparam int ROW_W      = 16;
    localparam int SLOT_W     = 6;
    localparam int SPR_W      = 7;
    localparam int NR_W       = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_SLOT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_ROW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS      = 1'd1;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] addr;
        logic [VAL_W-1:0] value;
        logic             last;
        logic [ROW_W-1:0] row;
    } t_q_entry;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               full;
        logic               empty;
    } t_q_stat;

endpackage
`default_nettype wire

// ----- rtl/esm_in_if.sv -----
// Input channel: vector loads and matrix slots.
`default_nettype none
interface esm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [11:0] vec_index;
    logic [31:0] vec_value;
    logic [11:0] col_index;
    logic [31:0] mat_value;

    modport source (output valid, kind, vec_index, vec_value, col_index, mat_value,
                    input ready);
    modport sink   (input valid, kind, vec_index, vec_value, col_index, mat_value,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/esm_out_if.sv -----
// Output channel: row index and saturated row sum.
`default_nettype none
interface esm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] row_index;
    logic [63:0] row_result;

    modport source (output valid, row_index, row_result, input ready);
    modport sink   (input valid, row_index, row_result, output ready);
endinterface
`default_nettype wire

// ----- rtl/esm_front.sv -----
// Front end: configuration registers, word acceptance, slot and row counting.
`default_nettype none
module esm_front (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [esm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [esm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    esm_in_if.sink                            i_in,
    input  wire                               i_full,
    output logic                              o_push,
    output esm_pkg::t_q_entry                 o_entry
);

    logic [esm_pkg::SPR_W-1:0]  r_spr;
    logic [esm_pkg::NR_W-1:0]   r_nr;
    logic [esm_pkg::SLOT_W-1:0] r_slot;
    logic [esm_pkg::ROW_W-1:0]  r_row;

    logic [esm_pkg::SPR_W-1:0]  w_spr_eff;
    logic [esm_pkg::NR_W-1:0]   w_nr_eff;
    logic [esm_pkg::SPR_W-1:0]  w_slot_inc;
    logic [esm_pkg::NR_W-1:0]   w_row_inc;
    logic                       w_last;
    logic                       w_wrap;

    always_comb begin
        if (r_spr == '0) begin
            w_spr_eff = esm_pkg::SPR_W'(1);
        end else if (r_spr > esm_pkg::SPR_W'(esm_pkg::MAX_SLOTS)) begin
            w_spr_eff = esm_pkg::SPR_W'(esm_pkg::MAX_SLOTS);
        end else begin
            w_spr_eff = r_spr;
        end
        if (r_nr == '0) begin
            w_nr_eff = esm_pkg::NR_W'(1);
        end else if (r_nr > esm_pkg::NR_W'(esm_pkg::MAX_ROWS)) begin
            w_nr_eff = esm_pkg::NR_W'(esm_pkg::MAX_ROWS);
        end else begin
            w_nr_eff = r_nr;
        end
    end

    assign w_slot_inc = {1'b0, r_slot} + esm_pkg::SPR_W'(1);
    assign w_row_inc  = {1'b0, r_row} + esm_pkg::NR_W'(1);
    assign w_last     = (w_slot_inc >= w_spr_eff);
    assign w_wrap     = (w_row_inc >= w_nr_eff);

    assign i_in.ready = i_rst_n && !i_full;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        o_entry.kind = i_in.kind;
        o_entry.last = w_last;
        o_entry.row  = r_row;
        if (i_in.kind == esm_pkg::KIND_LOAD) begin
            o_entry.addr  = i_in.vec_index;
            o_entry.value = i_in.vec_value;
        end else begin
            o_entry.addr  = i_in.col_index;
            o_entry.value = i_in.mat_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr  <= esm_pkg::SPR_W'(1);
            r_nr   <= esm_pkg::NR_W'(1);
            r_slot <= '0;
            r_row  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    esm_pkg::CFG_SLOTS_PER_ROW: r_spr <= i_cfg_data[esm_pkg::SPR_W-1:0];
                    esm_pkg::CFG_NUM_ROWS:      r_nr  <= i_cfg_data[esm_pkg::NR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (o_push && i_in.kind == esm_pkg::KIND_SLOT) begin
                if (w_last) begin
                    r_slot <= '0;
                    r_row  <= w_wrap ? '0 : w_row_inc[esm_pkg::ROW_W-1:0];
                end else begin
                    r_slot <= w_slot_inc[esm_pkg::SLOT_W-1:0];
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/esm_queue.sv -----
// Short queue between front end and back end.
`default_nettype none
module esm_queue (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  wire esm_pkg::t_q_entry   i_entry,
    input  wire                      i_pop,
    output esm_pkg::t_q_entry        o_head,
    output esm_pkg::t_q_stat         o_stat
);

    esm_pkg::t_q_entry           r_buf [esm_pkg::Q_DEPTH];
    logic [esm_pkg::Q_PTR_W-1:0] r_wr;
    logic [esm_pkg::Q_PTR_W-1:0] r_rd;
    logic [esm_pkg::Q_CNT_W-1:0] r_cnt;

    assign o_head       = r_buf[r_rd];
    assign o_stat.count = r_cnt;
    assign o_stat.full  = (r_cnt == esm_pkg::Q_CNT_W'(esm_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == esm_pkg::Q_PTR_W'(esm_pkg::Q_DEPTH - 1)) ? '0
                        : r_wr + esm_pkg::Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == esm_pkg::Q_PTR_W'(esm_pkg::Q_DEPTH - 1)) ? '0
                        : r_rd + esm_pkg::Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + esm_pkg::Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - esm_pkg::Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/esm_back.sv -----
// Back end: vector store, multiplier, saturating accumulator and output register.
`default_nettype none
module esm_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire esm_pkg::t_q_entry   i_head,
    input  wire                      i_empty,
    output logic                     o_pop,
    esm_out_if.source                o_out
);

    logic [esm_pkg::VAL_W-1:0]        r_mem [esm_pkg::VEC_DEPTH];

    logic                             r_v1;
    logic signed [esm_pkg::VAL_W-1:0] r_x1;
    logic signed [esm_pkg::VAL_W-1:0] r_m1;
    logic                             r_last1;
    logic [esm_pkg::ROW_W-1:0]        r_row1;

    logic                             r_v2;
    logic signed [esm_pkg::ACC_W-1:0] r_prod2;
    logic                             r_last2;
    logic [esm_pkg::ROW_W-1:0]        r_row2;

    logic [esm_pkg::ACC_W-1:0]        r_acc;
    logic                             r_ov;
    logic [esm_pkg::ROW_W-1:0]        r_orow;
    logic [esm_pkg::ACC_W-1:0]        r_ores;

    logic                             w_adv;
    logic signed [esm_pkg::ACC_W-1:0] w_prod;
    logic [esm_pkg::ACC_W-1:0]        w_raw;
    logic [esm_pkg::ACC_W-1:0]        w_sum;
    logic                             w_ovf;

    // Stall only when a row end meets a full, untaken output register.
    assign w_adv = !(r_v2 && r_last2 && r_ov && !o_out.ready);
    assign o_pop = w_adv && !i_empty;

    assign w_prod = r_x1 * r_m1;

    assign w_raw = r_acc + r_prod2;
    assign w_ovf = (r_acc[esm_pkg::ACC_W-1] == r_prod2[esm_pkg::ACC_W-1])
                && (w_raw[esm_pkg::ACC_W-1] != r_acc[esm_pkg::ACC_W-1]);
    always_comb begin
        if (w_ovf) begin
            w_sum = r_acc[esm_pkg::ACC_W-1] ? {1'b1, {(esm_pkg::ACC_W-1){1'b0}}}
                                            : {1'b0, {(esm_pkg::ACC_W-1){1'b1}}};
        end else begin
            w_sum = w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.kind == esm_pkg::KIND_LOAD) begin
            r_mem[i_head.addr] <= i_head.value;
        end
        if (o_pop && i_head.kind == esm_pkg::KIND_SLOT) begin
            r_x1 <= r_mem[i_head.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1    <= i_head.value;
            r_last1 <= i_head.last;
            r_row1  <= i_head.row;
            r_prod2 <= w_prod;
            r_last2 <= r_last1;
            r_row2  <= r_row1;
        end
        if (w_adv && r_v2 && r_last2) begin
            r_orow <= r_row2;
            r_ores <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_v1 <= o_pop && i_head.kind == esm_pkg::KIND_SLOT;
                r_v2 <= r_v1;
                if (r_v2) begin
                    r_acc <= r_last2 ? '0 : w_sum;
                end
            end
            if (w_adv && r_v2 && r_last2) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.row_index  = r_orow;
    assign o_out.row_result = r_ores;

endmodule
`default_nettype wire

// ----- rtl/ell_sparse_matvec.sv -----
// Top level of the ELLPACK sparse matrix-vector block.
`default_nettype none
// Kind 0 words load the 4096-entry vector store; kind 1 words are matrix slots taken
// row by row, slots_per_row of them per row, and the last slot of a row yields one
// output word with the row index and the saturated Q32.32 sum. One word is accepted
// per cycle while the queue is not full. A row's last slot passes the queue, the store
// read and the product register, and its sum is registered in the output register.
// Throughput is set by the single store read port and the one multiply-accumulate per
// cycle while the back end does not stall. A four-entry queue separates the input
// side from the arithmetic, and the output register lets the next row keep running
// while a result waits. Store entries read before being loaded return undefined data.
module ell_sparse_matvec (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [esm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [esm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    esm_in_if.sink                         i_in,
    esm_out_if.source                      o_out
);

    logic              w_push;
    logic              w_pop;
    esm_pkg::t_q_entry w_entry;
    esm_pkg::t_q_entry w_head;
    esm_pkg::t_q_stat  w_stat;

    esm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (w_stat.full),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    esm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    esm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_stat.empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= esm_pkg::Q_CNT_W'(esm_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    a_q_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("pop from empty queue");

    a_q_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (w_stat.count == $past(w_stat.count) + 1'b1))
        else $error("queue count missed a push");

endmodule
`default_nettype wire
